@@ src/lslf_pkg.sv @@
// Shared types, widths and helpers for the least-squares line fit block.
// Depends on nothing; used by least_squares_line_fit_top.
package lslf_pkg;

  localparam int MAX_POINTS = 1024;

  // Point counter holds 0..MAX_POINTS.
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  // Accumulator widths follow from the Q8.8 input range and the point limit.
  localparam int SX_W  = CNT_W + 16;   // signed sum of x or y
  localparam int SXX_W = CNT_W + 30;   // unsigned sum of x*x
  localparam int SXY_W = CNT_W + 31;   // signed sum of x*y
  // Multiplier operand of the shift-add multiply covers both n and Sx.
  localparam int MB_W  = SX_W;
  // Datapath width holds slope*Sx, the widest intermediate, with sign.
  localparam int DW     = 3 * CNT_W + 63;
  localparam int STEP_W = $clog2(DW);

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FEW   = 2'd1,
    ST_DEGEN = 2'd2,
    ST_MANY  = 2'd3
  } status_e;

  typedef struct packed {
    logic signed [15:0] x_value;
    logic signed [15:0] y_value;
    logic               last_point;
  } lslf_in_t;

  typedef struct packed {
    logic signed [31:0] slope;
    logic signed [31:0] intercept;
    status_e            status;
  } lslf_out_t;

  // Clamp a signed datapath word to signed 32 bits.
  function automatic logic [31:0] sat32(input logic [DW-1:0] v);
    logic [31:0] r;
    if (v[DW-1]) begin
      r = (&v[DW-1:31]) ? v[31:0] : 32'h8000_0000;
    end else begin
      r = (|v[DW-2:31]) ? 32'h7FFF_FFFF : v[31:0];
    end
    return r;
  endfunction

endpackage

@@ src/least_squares_line_fit_top.sv @@
// Least-squares line fit: point accumulation and the shared-adder sequencer
// that forms slope and intercept. Depends on lslf_pkg.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_data_i) carries one point per
//   request: x_value and y_value in signed Q8.8 and a last_point mark. Output
//   channel (out_valid_o / out_ready_i / out_data_o) carries one result per
//   set: slope and intercept in signed Q16.16, saturated, plus a status code.
//   For each point the accept cycle updates n, Sx and Sy, then a single
//   16x16 multiplier feeds Sxx and Sxy; in_ready_o stays low meanwhile.
//   On a last point a sequencer drives one 96-bit adder/subtractor through
//   five shift-add multiplies, a denominator check and two restoring
//   divides, then loads the result register. Too-many and too-few sets
//   go straight to the output step; a degenerate-x set stops after the
//   denominator check. Every error result carries zero slope and
//   intercept.
//   The result sits in an output register; the block accepts points for the
//   next set while it waits. If the receiver stalls when the next result is
//   ready, the sequencer holds in its output step until the register frees.
//   Reset (rst_ni low, asynchronous) clears all sums, the point count, the
//   overflow mark and the output valid; the block is ready right after.
module least_squares_line_fit_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  lslf_pkg::lslf_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output lslf_pkg::lslf_out_t out_data_o
);

  localparam int CNT_W  = lslf_pkg::CNT_W;
  localparam int SX_W   = lslf_pkg::SX_W;
  localparam int SXX_W  = lslf_pkg::SXX_W;
  localparam int SXY_W  = lslf_pkg::SXY_W;
  localparam int MB_W   = lslf_pkg::MB_W;
  localparam int DW     = lslf_pkg::DW;
  localparam int STEP_W = lslf_pkg::STEP_W;

  // Sequencer states
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_ACC_XX   = 4'd1;
  localparam logic [3:0] S_ACC_XY   = 4'd2;
  localparam logic [3:0] S_FIN      = 4'd3;
  localparam logic [3:0] S_MUL      = 4'd4;
  localparam logic [3:0] S_MUL_END  = 4'd5;
  localparam logic [3:0] S_DEN_CHK  = 4'd6;
  localparam logic [3:0] S_DIV_PREP = 4'd7;
  localparam logic [3:0] S_DIV      = 4'd8;
  localparam logic [3:0] S_DIV_END  = 4'd9;
  localparam logic [3:0] S_OUT      = 4'd10;

  // Which product the shared multiply is forming
  localparam logic [2:0] PH_NSXX  = 3'd0;
  localparam logic [2:0] PH_SXSX  = 3'd1;
  localparam logic [2:0] PH_NSXY  = 3'd2;
  localparam logic [2:0] PH_SXSY  = 3'd3;
  localparam logic [2:0] PH_SLOPE = 3'd4;

  logic [3:0] state_q, state_d;

  // Set accumulators
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [SX_W-1:0]  sx_q, sx_d;
  logic [SX_W-1:0]  sy_q, sy_d;
  logic [SXX_W-1:0] sxx_q, sxx_d;
  logic [SXY_W-1:0] sxy_q, sxy_d;
  logic             ovf_q, ovf_d;

  // Held point
  logic signed [15:0] x_q, x_d;
  logic signed [15:0] y_q, y_d;
  logic               last_q, last_d;

  // Fit datapath
  logic [DW-1:0]     acc_q, acc_d;   // product accumulator
  logic [DW-1:0]     mca_q, mca_d;   // multiplicand, shifts left
  logic [MB_W-1:0]   mcb_q, mcb_d;   // multiplier, shifts right
  logic [DW-1:0]     t_q, t_d;       // first product, later the slope
  logic [DW-1:0]     dvd_q, dvd_d;   // dividend magnitude / quotient
  logic [DW-1:0]     dsr_q, dsr_d;   // divisor
  logic [DW-1:0]     rem_q, rem_d;
  logic              neg_q, neg_d;
  logic              div_icpt_q, div_icpt_d;
  logic [2:0]        ph_q, ph_d;
  logic [STEP_W-1:0] step_q, step_d;
  lslf_pkg::status_e status_q, status_d;

  // Output register
  lslf_pkg::lslf_out_t out_q, out_d;
  logic                out_valid_q, out_valid_d;
  logic                out_load;

  // Shared adder/subtractor
  logic [DW-1:0] add_a, add_b, add_sum;
  logic          add_sub;

  // Point multiplier
  logic signed [15:0] pm_b;
  logic signed [31:0] pm_prod;

  logic               in_accept;
  logic               cnt_full;
  logic [DW-1:0]      rem_shift;
  logic [DW-1:0]      prep_op;
  logic [DW-1:0]      sx_ext, sy_sh16, sxx_ext, sxy_ext;
  logic [MB_W-1:0]    n_mb;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_accept   = in_valid_i && in_ready_o;
  assign cnt_full    = (cnt_q == CNT_W'(lslf_pkg::MAX_POINTS));
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_load    = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  assign pm_b    = (state_q == S_ACC_XX) ? x_q : y_q;
  assign pm_prod = x_q * pm_b;

  assign sx_ext  = {{(DW-SX_W){sx_q[SX_W-1]}}, sx_q};
  assign sy_sh16 = {{(DW-SX_W-16){sy_q[SX_W-1]}}, sy_q, 16'h0000};
  assign sxx_ext = {{(DW-SXX_W){1'b0}}, sxx_q};
  assign sxy_ext = {{(DW-SXY_W){sxy_q[SXY_W-1]}}, sxy_q};
  assign n_mb    = {{(MB_W-CNT_W){1'b0}}, cnt_q};

  assign rem_shift = {rem_q[DW-2:0], dvd_q[DW-1]};
  // Slope divides num*2^16, intercept divides its numerator as it stands
  assign prep_op   = div_icpt_q ? dvd_q : {dvd_q[DW-17:0], 16'h0000};

  // Operand select for the one wide adder
  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    case (state_q)
      S_MUL: begin
        add_a   = acc_q;
        add_b   = mca_q;
        // sign bit of the multiplier weighs negative
        add_sub = (step_q == STEP_W'(MB_W - 1));
      end
      S_MUL_END: begin
        add_a   = (ph_q == PH_SLOPE) ? sy_sh16 : t_q;
        add_b   = acc_q;
        add_sub = 1'b1;
      end
      S_DIV: begin
        add_a   = rem_shift;
        add_b   = dsr_q;
        add_sub = 1'b1;
      end
      S_DIV_PREP: begin
        add_b   = prep_op;
        add_sub = 1'b1;
      end
      S_DIV_END: begin
        add_b   = dvd_q;
        add_sub = 1'b1;
      end
      default: begin
        add_sub = 1'b0;
      end
    endcase
  end

  assign add_sum = add_a + (add_b ^ {DW{add_sub}}) + {{(DW-1){1'b0}}, add_sub};

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    sx_d       = sx_q;
    sy_d       = sy_q;
    sxx_d      = sxx_q;
    sxy_d      = sxy_q;
    ovf_d      = ovf_q;
    x_d        = x_q;
    y_d        = y_q;
    last_d     = last_q;
    acc_d      = acc_q;
    mca_d      = mca_q;
    mcb_d      = mcb_q;
    t_d        = t_q;
    dvd_d      = dvd_q;
    dsr_d      = dsr_q;
    rem_d      = rem_q;
    neg_d      = neg_q;
    div_icpt_d = div_icpt_q;
    ph_d       = ph_q;
    step_d     = step_q;
    status_d   = status_q;
    out_d      = out_q;
    out_valid_d = out_valid_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          x_d    = in_data_i.x_value;
          y_d    = in_data_i.y_value;
          last_d = in_data_i.last_point;
          if (cnt_full) begin
            // drop the point, remember the set overran
            ovf_d   = 1'b1;
            state_d = in_data_i.last_point ? S_FIN : S_IDLE;
          end else begin
            cnt_d   = cnt_q + 1'b1;
            sx_d    = sx_q + {{(SX_W-16){in_data_i.x_value[15]}}, in_data_i.x_value};
            sy_d    = sy_q + {{(SX_W-16){in_data_i.y_value[15]}}, in_data_i.y_value};
            state_d = S_ACC_XX;
          end
        end
      end
      S_ACC_XX: begin
        sxx_d   = sxx_q + {{(SXX_W-31){1'b0}}, pm_prod[30:0]};
        state_d = S_ACC_XY;
      end
      S_ACC_XY: begin
        sxy_d   = sxy_q + {{(SXY_W-32){pm_prod[31]}}, pm_prod};
        state_d = last_q ? S_FIN : S_IDLE;
      end
      S_FIN: begin
        if (ovf_q) begin
          status_d = lslf_pkg::ST_MANY;
          state_d  = S_OUT;
        end else if (cnt_q < CNT_W'(2)) begin
          status_d = lslf_pkg::ST_FEW;
          state_d  = S_OUT;
        end else begin
          status_d = lslf_pkg::ST_OK;
          acc_d    = '0;
          mca_d    = sxx_ext;
          mcb_d    = n_mb;
          step_d   = '0;
          ph_d     = PH_NSXX;
          state_d  = S_MUL;
        end
      end
      S_MUL: begin
        if (mcb_q[0]) begin
          acc_d = add_sum;
        end
        mca_d  = {mca_q[DW-2:0], 1'b0};
        mcb_d  = {1'b0, mcb_q[MB_W-1:1]};
        step_d = step_q + 1'b1;
        if (step_q == STEP_W'(MB_W - 1)) begin
          state_d = S_MUL_END;
        end
      end
      S_MUL_END: begin
        // start the next product by default
        acc_d   = '0;
        step_d  = '0;
        state_d = S_MUL;
        case (ph_q)
          PH_NSXX: begin
            t_d   = acc_q;
            mca_d = sx_ext;
            mcb_d = sx_q;
            ph_d  = PH_SXSX;
          end
          PH_SXSX: begin
            dsr_d   = add_sum;           // denominator
            state_d = S_DEN_CHK;
          end
          PH_NSXY: begin
            t_d   = acc_q;
            mca_d = sx_ext;
            mcb_d = sy_q;
            ph_d  = PH_SXSY;
          end
          PH_SXSY: begin
            dvd_d      = add_sum;        // slope numerator
            div_icpt_d = 1'b0;
            state_d    = S_DIV_PREP;
          end
          PH_SLOPE: begin
            dvd_d      = add_sum;        // intercept numerator
            dsr_d      = {{(DW-CNT_W-8){1'b0}}, cnt_q, 8'h00};
            div_icpt_d = 1'b1;
            state_d    = S_DIV_PREP;
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      S_DEN_CHK: begin
        if ((dsr_q == '0) || dsr_q[DW-1]) begin
          status_d = lslf_pkg::ST_DEGEN;
          state_d  = S_OUT;
        end else begin
          acc_d   = '0;
          mca_d   = sxy_ext;
          mcb_d   = n_mb;
          step_d  = '0;
          ph_d    = PH_NSXY;
          state_d = S_MUL;
        end
      end
      S_DIV_PREP: begin
        // divide magnitudes, restore the sign afterwards
        neg_d   = prep_op[DW-1];
        dvd_d   = prep_op[DW-1] ? add_sum : prep_op;
        rem_d   = '0;
        step_d  = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        if (!add_sum[DW-1]) begin
          rem_d = add_sum;
          dvd_d = {dvd_q[DW-2:0], 1'b1};
        end else begin
          rem_d = rem_shift;
          dvd_d = {dvd_q[DW-2:0], 1'b0};
        end
        step_d = step_q + 1'b1;
        if (step_q == STEP_W'(DW - 1)) begin
          state_d = S_DIV_END;
        end
      end
      S_DIV_END: begin
        if (div_icpt_q) begin
          dvd_d   = neg_q ? add_sum : dvd_q;
          state_d = S_OUT;
        end else begin
          // unsaturated slope feeds slope*Sx
          t_d     = neg_q ? add_sum : dvd_q;
          acc_d   = '0;
          mca_d   = neg_q ? add_sum : dvd_q;
          mcb_d   = sx_q;
          step_d  = '0;
          ph_d    = PH_SLOPE;
          state_d = S_MUL;
        end
      end
      S_OUT: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          out_d.status = status_q;
          if (status_q == lslf_pkg::ST_OK) begin
            out_d.slope     = lslf_pkg::sat32(t_q);
            out_d.intercept = lslf_pkg::sat32(dvd_q);
          end else begin
            out_d.slope     = '0;
            out_d.intercept = '0;
          end
          // clear the set
          cnt_d   = '0;
          sx_d    = '0;
          sy_d    = '0;
          sxx_d   = '0;
          sxy_d   = '0;
          ovf_d   = 1'b0;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      sx_q        <= '0;
      sy_q        <= '0;
      sxx_q       <= '0;
      sxy_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      sx_q        <= sx_d;
      sy_q        <= sy_d;
      sxx_q       <= sxx_d;
      sxy_q       <= sxy_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q        <= x_d;
    y_q        <= y_d;
    last_q     <= last_d;
    acc_q      <= acc_d;
    mca_q      <= mca_d;
    mcb_q      <= mcb_d;
    t_q        <= t_d;
    dvd_q      <= dvd_d;
    dsr_q      <= dsr_d;
    rem_q      <= rem_d;
    neg_q      <= neg_d;
    div_icpt_q <= div_icpt_d;
    ph_q       <= ph_d;
    step_q     <= step_d;
    status_q   <= status_d;
    out_q      <= out_d;
  end

  // The overflow mark only appears once the count has reached its limit
  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> cnt_full)
    else $error("overflow mark set below the point limit");

  // Error results carry zero slope and intercept
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.status != lslf_pkg::ST_OK)) |->
      (out_data_o.slope == '0) && (out_data_o.intercept == '0))
    else $error("error result with nonzero fields");

  // The divider never runs on a zero divisor
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (dsr_q != '0))
    else $error("divide with zero divisor");

  // Issuing a result clears the set
  a_set_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (cnt_q == '0) && (sx_q == '0) && (sxx_q == '0) && !ovf_q && out_valid_o)
    else $error("set not cleared after result");

endmodule

@@ sim/least_squares_line_fit_top_test.sv @@
`timescale 1ns / 100ps
// Self-checking bench for least_squares_line_fit_top: streams point sets,
// predicts slope, intercept and status per set and checks every result.
// Depends on lslf_pkg and least_squares_line_fit_top.
module least_squares_line_fit_top_test;

  localparam int RESET_CYCLES    = 5;
  // Generous bound for the worst case, where every point closes a set under
  // the longest stalls.
  localparam int CYCLE_LIMIT     = 5_000_000;
  // Watch time after the last owed fit arrives, to catch stray results.
  localparam int SETTLE_CYCLES   = 400;
  localparam int RANDOM_POINTS   = 1725;
  localparam int MIN_RANDOM_SETS = 50;
  localparam int MAX_REPORTS     = 100;

  typedef logic signed [127:0] wide_t;

  localparam wide_t Q16_MAX = 128'sd2147483647;
  localparam wide_t Q16_MIN = -128'sd2147483648;

  typedef enum int {
    SHAPE_FULL,     // any 16-bit x and y
    SHAPE_SMALL,    // values near zero
    SHAPE_EXTREME,  // corner values only
    SHAPE_LINEAR,   // points near a random line
    SHAPE_FLAT_X    // one x for the whole set
  } set_shape_e;

  typedef struct {
    lslf_pkg::lslf_in_t point;
    bit                 drain_first;  // hold this request until no result is owed
  } pending_point_t;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  lslf_pkg::lslf_in_t  in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  lslf_pkg::lslf_out_t out_data;

  // Requests waiting to be driven, and the fits owed by the block.
  pending_point_t      point_queue[$];
  lslf_pkg::lslf_out_t expected_fits[$];

  // Running sums of the set being accumulated.
  int unsigned fit_count    = 0;
  longint      fit_sum_x    = 0;
  longint      fit_sum_y    = 0;
  longint      fit_sum_xx   = 0;
  longint      fit_sum_xy   = 0;
  bit          fit_overflow = 1'b0;

  int unsigned total_points    = 0;
  int unsigned accepted_points = 0;
  int unsigned fail_count      = 0;
  int unsigned cycle_count     = 0;
  int unsigned sender_gap      = 0;
  int unsigned receiver_gap    = 0;
  bit          sender_calm     = 1'b0;
  bit          receiver_calm   = 1'b0;

  least_squares_line_fit_top i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  // 4 ns clock: 2 ns high, 2 ns low.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Fit predictor
  // ---------------------------------------------------------------------

  // Clamp an exact value to signed Q16.16.
  function automatic logic [31:0] clamp_q16(input wide_t v);
    if (v > Q16_MAX) return 32'h7FFF_FFFF;
    if (v < Q16_MIN) return 32'h8000_0000;
    return v[31:0];
  endfunction

  // Solve the set held in the running sums; all arithmetic is exact.
  function automatic lslf_pkg::lslf_out_t fit_solve();
    lslf_pkg::lslf_out_t r;
    wide_t               n, sx, sy, sxx, sxy, den, num, slope, icpt;
    r        = '0;
    r.status = lslf_pkg::ST_OK;
    n   = fit_count;
    sx  = fit_sum_x;
    sy  = fit_sum_y;
    sxx = fit_sum_xx;
    sxy = fit_sum_xy;
    if (fit_overflow) begin
      r.status = lslf_pkg::ST_MANY;
    end else if (fit_count < 2) begin
      r.status = lslf_pkg::ST_FEW;
    end else begin
      den = n * sxx - sx * sx;
      if (den <= 0) begin
        r.status = lslf_pkg::ST_DEGEN;
      end else begin
        // Both divisions truncate toward zero; the intercept takes the
        // slope before clamping.
        num         = n * sxy - sx * sy;
        slope       = (num <<< 16) / den;
        icpt        = ((sy <<< 16) - slope * sx) / (n <<< 8);
        r.slope     = clamp_q16(slope);
        r.intercept = clamp_q16(icpt);
      end
    end
    return r;
  endfunction

  // Fold one accepted request into the sums; owe a fit on the last point.
  task automatic fit_accumulate(input lslf_pkg::lslf_in_t p);
    longint x, y;
    x = longint'(signed'(p.x_value));
    y = longint'(signed'(p.y_value));
    if (fit_count >= lslf_pkg::MAX_POINTS) begin
      // Drop points past the limit, but remember the set is too long.
      fit_overflow = 1'b1;
    end else begin
      fit_count++;
      fit_sum_x  += x;
      fit_sum_y  += y;
      fit_sum_xx += x * x;
      fit_sum_xy += x * y;
    end
    if (p.last_point) begin
      expected_fits.insert(expected_fits.size(), fit_solve());
      fit_count    = 0;
      fit_sum_x    = 0;
      fit_sum_y    = 0;
      fit_sum_xx   = 0;
      fit_sum_xy   = 0;
      fit_overflow = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("%0t ns mismatch: %s", $realtime, msg);
  endtask

  // Compare a delivered fit with the oldest one owed.
  task automatic check_fit(input lslf_pkg::lslf_out_t got);
    lslf_pkg::lslf_out_t want;
    if (expected_fits.size() == 0) begin
      report_mismatch($sformatf("result with none owed: slope %0d intercept %0d status %0d",
                                got.slope, got.intercept, got.status));
      return;
    end
    want = expected_fits.pop_front();
    if (got.slope !== want.slope)
      report_mismatch($sformatf("slope %0d, want %0d", got.slope, want.slope));
    if (got.intercept !== want.intercept)
      report_mismatch($sformatf("intercept %0d, want %0d", got.intercept, want.intercept));
    if (got.status !== want.status)
      report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
  endtask

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  // Idle length: mostly short, now and then long.
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 3);
    if (r < 90) return $urandom_range(4, 12);
    return $urandom_range(13, 40);
  endfunction

  function automatic int clamp16(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic int rand16();
    logic signed [15:0] v;
    v = 16'($urandom());
    return int'(v);
  endfunction

  function automatic int extreme16();
    case ($urandom_range(0, 5))
      0:       return -32768;
      1:       return -32767;
      2:       return -1;
      3:       return 0;
      4:       return 1;
      default: return 32767;
    endcase
  endfunction

  task automatic queue_point(input int x, input int y, input bit last, input bit drain);
    pending_point_t e;
    e.point.x_value    = 16'(clamp16(x));
    e.point.y_value    = 16'(clamp16(y));
    e.point.last_point = last;
    e.drain_first      = drain;
    point_queue.insert(point_queue.size(), e);
  endtask

  // Queue one complete set; only its last point carries the mark.
  task automatic queue_set(input int size, input set_shape_e shape, input bit drain);
    int gain, offset, flat_x, x, y;
    gain   = int'($urandom_range(0, 64)) - 32;   // slope in quarter steps
    offset = int'($urandom_range(0, 16000)) - 8000;
    flat_x = rand16();
    for (int i = 0; i < size; i++) begin
      case (shape)
        SHAPE_FULL: begin
          x = rand16();
          y = rand16();
        end
        SHAPE_SMALL: begin
          x = int'($urandom_range(0, 16)) - 8;
          y = int'($urandom_range(0, 16)) - 8;
        end
        SHAPE_EXTREME: begin
          x = extreme16();
          y = extreme16();
        end
        SHAPE_LINEAR: begin
          x = int'($urandom_range(0, 4000)) - 2000;
          y = (gain * x) / 4 + offset + int'($urandom_range(0, 32)) - 16;
        end
        default: begin
          x = flat_x;
          y = rand16();
        end
      endcase
      queue_point(x, y, i == size - 1, drain && i == 0);
    end
  endtask

  function automatic int pick_set_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 6) return 1;
    if (r < 70) return $urandom_range(2, 6);
    if (r < 95) return $urandom_range(7, 30);
    return $urandom_range(31, 60);
  endfunction

  function automatic set_shape_e pick_set_shape();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 35) return SHAPE_FULL;
    if (r < 50) return SHAPE_SMALL;
    if (r < 62) return SHAPE_EXTREME;
    if (r < 92) return SHAPE_LINEAR;
    return SHAPE_FLAT_X;
  endfunction

  // ---------------------------------------------------------------------
  // Driver: present queued requests, idle at random between them
  // ---------------------------------------------------------------------
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      in_data    <= '0;
      sender_gap <= 0;
    end else begin
      bit             take_next;
      pending_point_t next_req;
      take_next = !in_valid || in_ready;
      // Predict from the request the block takes at this edge.
      if (in_valid && in_ready) begin
        fit_accumulate(in_data);
        accepted_points++;
      end
      // Toggle stretches of back-to-back requests.
      if ($urandom_range(0, 499) == 0) sender_calm <= !sender_calm;
      if (take_next) begin
        if (sender_gap != 0) begin
          sender_gap <= sender_gap - 1;
          in_valid   <= 1'b0;
        end else if (point_queue.size() != 0 &&
                     !(point_queue[0].drain_first && expected_fits.size() != 0)) begin
          // Load the next request; draw the idle that follows its acceptance.
          next_req   = point_queue.pop_front();
          in_valid   <= 1'b1;
          in_data    <= next_req.point;
          sender_gap <= (sender_calm || $urandom_range(0, 2) != 0) ? 0 : gap_len();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: check each delivered fit, stall the result channel at random
  // ---------------------------------------------------------------------
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready    <= 1'b0;
      receiver_gap <= 0;
    end else begin
      if (out_valid && out_ready) check_fit(out_data);
      if ($urandom_range(0, 499) == 0) receiver_calm <= !receiver_calm;
      if (receiver_gap != 0) begin
        receiver_gap <= receiver_gap - 1;
        out_ready    <= 1'b0;
      end else if (!receiver_calm && $urandom_range(0, 11) == 0) begin
        // Rare long stalls make a finished fit wait in the output register.
        out_ready    <= 1'b0;
        receiver_gap <= ($urandom_range(0, 49) == 0) ? $urandom_range(100, 300) : gap_len();
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run if it hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[least_squares_line_fit_top] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------
  initial begin
    int         random_points;
    int         random_sets;
    int         size;
    set_shape_e shape;
    bit         drain;

    // Directed sets.
    // Single point: too few points.
    queue_point(-32768, 32767, 1'b1, 1'b0);
    // Two points with equal x: degenerate.
    queue_point(32767, -32768, 1'b0, 1'b0);
    queue_point(32767, 0, 1'b1, 1'b0);
    // Full-range span of x and y.
    queue_point(-32768, 32767, 1'b0, 1'b0);
    queue_point(32767, -32768, 1'b1, 1'b0);
    // Unit step in x with full swing in y: slope clamps high, then low.
    queue_point(0, -32768, 1'b0, 1'b0);
    queue_point(1, 32767, 1'b1, 1'b0);
    queue_point(0, 32767, 1'b0, 1'b0);
    queue_point(1, -32768, 1'b1, 1'b0);
    // Steep line far out in x: intercept clamps low, then high.
    queue_point(32766, -32768, 1'b0, 1'b0);
    queue_point(32767, 32767, 1'b1, 1'b0);
    queue_point(32766, 32767, 1'b0, 1'b0);
    queue_point(32767, -32768, 1'b1, 1'b0);
    // All points at the origin: degenerate.
    queue_point(0, 0, 1'b0, 1'b0);
    queue_point(0, 0, 1'b0, 1'b0);
    queue_point(0, 0, 1'b1, 1'b0);
    // Exact line y = x: slope 1.0, intercept 0.
    queue_point(256, 256, 1'b0, 1'b0);
    queue_point(512, 512, 1'b0, 1'b0);
    queue_point(-256, -256, 1'b1, 1'b0);
    // Mixed signs with both x extremes.
    queue_point(-1, 5, 1'b0, 1'b0);
    queue_point(1, -5, 1'b0, 1'b0);
    queue_point(32767, 0, 1'b0, 1'b0);
    queue_point(-32768, 0, 1'b1, 1'b0);

    // Random sets. One full-length set rides along: past the limit with a
    // single x, where the too-many status must win over the degenerate one.
    random_points = 0;
    random_sets   = 0;
    while (random_points < RANDOM_POINTS || random_sets < MIN_RANDOM_SETS) begin
      drain = 1'b0;
      if (random_sets == 20) begin
        size  = lslf_pkg::MAX_POINTS + 1 + int'($urandom_range(0, 3));
        shape = SHAPE_FLAT_X;
        drain = 1'b1;
      end else begin
        size  = pick_set_size();
        shape = pick_set_shape();
        // Hold off the first random set until the block has drained.
        drain = (random_sets == 0);
      end
      queue_set(size, shape, drain);
      random_points += size;
      random_sets++;
    end
    total_points = point_queue.size();

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every request to be taken, every owed fit to arrive, then
    // watch a while longer for stray results.
    while (accepted_points != total_points) @(posedge clk);
    while (expected_fits.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("[least_squares_line_fit_top] OK");
    end else begin
      $display("[least_squares_line_fit_top] ERROR");
    end
    $finish;
  end

endmodule
